[src/contiguous_page_slot_allocator_assert.svh]
// Assertion macros used by the slot allocator back end.
`ifndef CONTIGUOUS_PAGE_SLOT_ALLOCATOR_ASSERT_SVH
`define CONTIGUOUS_PAGE_SLOT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define CPSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define CPSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/cpsa_pkg.sv]
// Shared constants, types and helper functions of the slot allocator.
package cpsa_pkg;

    localparam int TOTAL_PAGES  = 4096;
    localparam int MAX_RUN      = 16;
    localparam int PAGE_W       = 12;
    localparam int RUN_W        = 5;
    localparam int FREE_W       = 13;
    localparam int FREE_MAX     = (2 ** FREE_W) - 1;
    localparam int SLOT_W       = $clog2(TOTAL_PAGES);
    localparam int DYN_W        = SLOT_W + 1;
    localparam int ROW_W        = 16;
    localparam int ROW_BW       = $clog2(ROW_W);
    localparam int ROWS         = TOTAL_PAGES / ROW_W;
    localparam int ROW_AW       = SLOT_W - ROW_BW;
    localparam int Q_DEPTH      = 2;
    localparam int Q_AW         = $clog2(Q_DEPTH);
    localparam int Q_CW         = $clog2(Q_DEPTH + 1);
    localparam int DIRECT_RESET = 1024;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_MAP   = 2'd2,
        OP_NONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        K_PASS,
        K_FAIL,
        K_ALLOC,
        K_MAP,
        K_FREE
    } t_kind;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RD,
        S_SCAN,
        S_WRD,
        S_WMOD
    } t_state;

    typedef struct packed {
        t_kind              kind;
        logic [PAGE_W-1:0]  page;
        logic [RUN_W-1:0]   cnt;
    } t_cmd;

    typedef struct packed {
        logic valid;
        logic full;
    } t_q_stat;

    typedef struct packed {
        logic              we;
        logic [PAGE_W-1:0] data;
    } t_cfg_wr;

    function automatic logic [DYN_W-1:0] dyn_of(input logic [PAGE_W-1:0] direct);
        logic [DYN_W:0] d;
        d = (DYN_W+1)'(direct);
        if (d >= (DYN_W+1)'(TOTAL_PAGES)) begin
            return '0;
        end
        return DYN_W'((DYN_W+1)'(TOTAL_PAGES) - d);
    endfunction

    function automatic logic run_ok(input logic [RUN_W-1:0] cnt);
        return (cnt != '0) && ((RUN_W+1)'(cnt) <= (RUN_W+1)'(MAX_RUN));
    endfunction

    function automatic logic [FREE_W-1:0] free_add(input logic [FREE_W-1:0] f,
                                                   input logic [RUN_W-1:0] n);
        logic [FREE_W:0] s;
        s = (FREE_W+1)'(f) + (FREE_W+1)'(n);
        if (s > (FREE_W+1)'(FREE_MAX)) begin
            return FREE_W'(FREE_MAX);
        end
        return FREE_W'(s);
    endfunction

    function automatic logic [FREE_W-1:0] free_sub(input logic [FREE_W-1:0] f,
                                                   input logic [RUN_W-1:0] n);
        if (f > FREE_W'(n)) begin
            return f - FREE_W'(n);
        end
        return '0;
    endfunction

endpackage

[src/cpsa_front.sv]
// Command intake: accept a request and classify it for the back end.
module cpsa_front (
    input  logic                       i_start,
    input  logic [1:0]                 i_op,
    input  logic [cpsa_pkg::PAGE_W-1:0] i_page_number,
    input  logic [cpsa_pkg::RUN_W-1:0]  i_count,
    input  logic [cpsa_pkg::PAGE_W-1:0] i_direct,
    input  cpsa_pkg::t_q_stat          i_q_stat,
    output logic                       o_busy,
    output logic                       o_push,
    output cpsa_pkg::t_cmd             o_cmd
);
    import cpsa_pkg::*;

    logic w_direct_hit;

    assign o_busy       = i_q_stat.full;
    assign o_push       = i_start && !i_q_stat.full;
    assign w_direct_hit = i_page_number < i_direct;

    always_comb begin
        o_cmd.page = i_page_number;
        o_cmd.cnt  = i_count;
        o_cmd.kind = K_FAIL;
        case (t_op'(i_op))
            OP_ALLOC: begin
                o_cmd.kind = run_ok(i_count) ? K_ALLOC : K_FAIL;
            end
            OP_FREE: begin
                if (!run_ok(i_count)) begin
                    o_cmd.kind = K_FAIL;
                end else if (w_direct_hit) begin
                    // direct page: succeed, no page reported
                    o_cmd.kind = K_PASS;
                    o_cmd.page = '0;
                end else begin
                    o_cmd.kind = K_FREE;
                end
            end
            OP_MAP: begin
                o_cmd.cnt  = RUN_W'(1);
                o_cmd.kind = w_direct_hit ? K_PASS : K_MAP;
            end
            default: begin
                o_cmd.kind = K_FAIL;
            end
        endcase
    end

endmodule

[src/cpsa_queue.sv]
// Two-entry command queue between intake and execution.
module cpsa_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  cpsa_pkg::t_cmd    i_cmd,
    input  logic              i_pop,
    output cpsa_pkg::t_cmd    o_cmd,
    output cpsa_pkg::t_q_stat o_stat
);
    import cpsa_pkg::*;

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wp;
    logic [Q_AW-1:0] r_rp;
    logic [Q_CW-1:0] r_cnt;
    logic            w_pop;

    assign w_pop        = i_pop && (r_cnt != '0);
    assign o_cmd        = r_mem[r_rp];
    assign o_stat.valid = r_cnt != '0;
    assign o_stat.full  = r_cnt == Q_CW'(Q_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == Q_AW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

[src/cpsa_back.sv]
// Execution engine: occupancy map, downward run scan, mark and clear.
module cpsa_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cpsa_pkg::t_cfg_wr            i_cfg,
    input  logic [cpsa_pkg::PAGE_W-1:0]  i_direct,
    input  cpsa_pkg::t_q_stat            i_q_stat,
    input  cpsa_pkg::t_cmd               i_cmd,
    output logic                         o_pop,
    output logic                         o_done,
    output logic                         o_ok,
    output logic [cpsa_pkg::PAGE_W-1:0]  o_result_page,
    output logic [cpsa_pkg::FREE_W-1:0]  o_free_slots
);
    import cpsa_pkg::*;
    `include "contiguous_page_slot_allocator_assert.svh"

    logic [ROW_W-1:0]  r_mem [ROWS];
    logic [ROWS-1:0]   r_vld;
    logic [ROW_W-1:0]  r_rdata;
    logic              r_rvld;

    t_state            r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [SLOT_W-1:0] r_pos, n_pos;
    logic [RUN_W-1:0]  r_streak, n_streak;
    logic [SLOT_W-1:0] r_lo, n_lo;
    logic [SLOT_W-1:0] r_hi, n_hi;
    logic [ROW_AW-1:0] r_row, n_row;
    logic              r_set, n_set;
    logic [SLOT_W-1:0] r_hint, n_hint;
    logic [FREE_W-1:0] r_free, n_free;
    logic              r_done, n_done;
    logic              r_ok, n_ok;
    logic [PAGE_W-1:0] r_res, n_res;

    logic              w_re;
    logic [ROW_AW-1:0] w_raddr;
    logic              w_we;
    logic [ROW_W-1:0]  w_wdata;
    logic [ROW_W-1:0]  w_row;
    logic [ROW_W-1:0]  w_mask;
    logic [DYN_W-1:0]  w_dyn;
    logic [DYN_W-1:0]  w_cfg_dyn;
    logic [SLOT_W-1:0] w_s;
    logic [DYN_W-1:0]  w_end;
    logic              w_bit_free;
    logic [RUN_W-1:0]  w_streak_inc;
    logic [SLOT_W-1:0] w_cnt_x;

    assign w_dyn        = dyn_of(i_direct);
    assign w_cfg_dyn    = dyn_of(i_cfg.data);
    assign w_row        = r_rvld ? r_rdata : '0;
    assign w_s          = SLOT_W'(i_cmd.page - i_direct);
    assign w_end        = DYN_W'(w_s) + DYN_W'(i_cmd.cnt);
    assign w_cnt_x      = SLOT_W'(r_cmd.cnt);
    assign w_bit_free   = !w_row[r_pos[ROW_BW-1:0]] && (DYN_W'(r_pos) < w_dyn);
    assign w_streak_inc = w_bit_free ? r_streak + 1'b1 : '0;

    always_comb begin
        for (int j = 0; j < ROW_W; j++) begin
            w_mask[j] = ({r_row, ROW_BW'(j)} >= r_lo) && ({r_row, ROW_BW'(j)} <= r_hi);
        end
    end

    // occupancy map rows
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_row] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg.we) begin
            r_vld  <= '0;
            r_rvld <= 1'b0;
        end else begin
            if (w_we) begin
                r_vld[r_row] <= 1'b1;
            end
            if (w_re) begin
                r_rvld <= r_vld[w_raddr];
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        n_cmd    = r_cmd;
        n_pos    = r_pos;
        n_streak = r_streak;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_row    = r_row;
        n_set    = r_set;
        n_hint   = r_hint;
        n_free   = r_free;
        n_done   = 1'b0;
        n_ok     = r_ok;
        n_res    = r_res;
        o_pop    = 1'b0;
        w_re     = 1'b0;
        w_raddr  = r_row;
        w_we     = 1'b0;
        w_wdata  = r_set ? (w_row | w_mask) : (w_row & ~w_mask);
        case (r_state)
            S_IDLE: begin
                if (i_q_stat.valid) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    case (i_cmd.kind)
                        K_PASS: begin
                            n_done = 1'b1;
                            n_ok   = 1'b1;
                            n_res  = i_cmd.page;
                        end
                        K_ALLOC, K_MAP: begin
                            if (r_hint < SLOT_W'(i_cmd.cnt)) begin
                                n_done = 1'b1;
                                n_ok   = 1'b0;
                                n_res  = '0;
                            end else begin
                                n_pos    = r_hint;
                                n_streak = '0;
                                n_state  = S_RD;
                            end
                        end
                        K_FREE: begin
                            n_res  = '0;
                            if (w_end <= w_dyn) begin
                                n_lo    = w_s;
                                n_hi    = SLOT_W'(w_end - 1'b1);
                                n_row   = w_s[SLOT_W-1:ROW_BW];
                                n_set   = 1'b0;
                                n_state = S_WRD;
                                if (SLOT_W'(w_end - 1'b1) > r_hint) begin
                                    n_hint = SLOT_W'(w_end - 1'b1);
                                end
                            end else begin
                                n_done = 1'b1;
                                n_ok   = 1'b0;
                                n_free = free_add(r_free, i_cmd.cnt);
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                            n_ok   = 1'b0;
                            n_res  = '0;
                        end
                    endcase
                end
            end
            S_RD: begin
                w_re    = 1'b1;
                w_raddr = r_pos[SLOT_W-1:ROW_BW];
                n_state = S_SCAN;
            end
            S_SCAN: begin
                n_streak = w_streak_inc;
                if (w_streak_inc == r_cmd.cnt) begin
                    // run starts at this slot and ends count-1 above it
                    n_lo    = r_pos;
                    n_hi    = r_pos + w_cnt_x - 1'b1;
                    n_row   = r_pos[SLOT_W-1:ROW_BW];
                    n_set   = 1'b1;
                    n_res   = PAGE_W'(i_direct + PAGE_W'(r_pos));
                    n_state = S_WRD;
                    if (r_cmd.kind == K_MAP) begin
                        n_hint = r_pos;
                    end else if (r_pos + w_cnt_x - 1'b1 == r_hint) begin
                        n_hint = r_pos - 1'b1;
                    end
                end else if (r_pos == SLOT_W'(1)) begin
                    n_done  = 1'b1;
                    n_ok    = 1'b0;
                    n_res   = '0;
                    n_state = S_IDLE;
                end else begin
                    n_pos = r_pos - 1'b1;
                    if (r_pos[ROW_BW-1:0] == '0) begin
                        n_state = S_RD;
                    end
                end
            end
            S_WRD: begin
                w_re    = 1'b1;
                w_raddr = r_row;
                n_state = S_WMOD;
            end
            S_WMOD: begin
                w_we = 1'b1;
                if (r_row != r_hi[SLOT_W-1:ROW_BW]) begin
                    n_row   = r_row + 1'b1;
                    n_state = S_WRD;
                end else begin
                    n_done  = 1'b1;
                    n_ok    = 1'b1;
                    n_state = S_IDLE;
                    n_free  = r_set ? free_sub(r_free, r_cmd.cnt)
                                    : free_add(r_free, r_cmd.cnt);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_ok    <= 1'b0;
            r_res   <= '0;
            r_hint  <= SLOT_W'(dyn_of(PAGE_W'(DIRECT_RESET)) - 1'b1);
            r_free  <= FREE_W'(dyn_of(PAGE_W'(DIRECT_RESET)));
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_ok    <= n_ok;
            r_res   <= n_res;
            if (i_cfg.we) begin
                r_hint <= (w_cfg_dyn != '0) ? SLOT_W'(w_cfg_dyn - 1'b1) : '0;
                r_free <= FREE_W'(w_cfg_dyn);
            end else begin
                r_hint <= n_hint;
                r_free <= n_free;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_pos    <= n_pos;
        r_streak <= n_streak;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_row    <= n_row;
        r_set    <= n_set;
    end

    assign o_done        = r_done;
    assign o_ok          = r_ok;
    assign o_result_page = r_res;
    assign o_free_slots  = r_free;

    `CPSA_ASSERT_IMP(a_scan_no_slot0, i_clk, i_rst_n, r_state == S_SCAN, r_pos != '0,
        "scan reached slot 0")
    `CPSA_ASSERT_IMP(a_run_span, i_clk, i_rst_n, r_state == S_WMOD,
        (r_lo <= r_hi) && ((r_hi - r_lo) < SLOT_W'(MAX_RUN)), "bad run bounds")
    `CPSA_ASSERT_IMP(a_streak_below, i_clk, i_rst_n, r_state == S_SCAN,
        r_streak < r_cmd.cnt, "streak passed run length")
    `CPSA_ASSERT_IMP(a_free_moves_on_result, i_clk, i_rst_n,
        $past(i_rst_n) && !$past(i_cfg.we) && (r_free != $past(r_free)), r_done,
        "free count changed without a result")

endmodule

[src/contiguous_page_slot_allocator.sv]
// Top level of the contiguous page slot allocator.
//
//  channel   handshake                     payload
//  -------   ---------------------------   -------------------------------------
//  command   i_start, o_busy (low)         i_op, i_page_number, i_count
//  result    o_done (one-cycle strobe)     o_ok, o_result_page, o_free_slots
//  config    i_cfg_valid, o_cfg_ready      i_cfg_data (direct_pages)
//
// A command transfers when i_start is high and o_busy is low; two commands queue.
// Direct pages, bad counts and unknown ops are answered without touching the occupancy map.
// Allocate and map walk the occupancy map one slot per cycle downward from the
// hint, pausing to read each 16-slot row, then mark the run row by row (read, write).
// Free clears its run the same way. The receiver cannot stall: each o_done is one transfer.
// Reset and any config write restore every slot to free at once (row valid bits).
module contiguous_page_slot_allocator (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [1:0]                   i_op,
    input  logic [cpsa_pkg::PAGE_W-1:0]  i_page_number,
    input  logic [cpsa_pkg::RUN_W-1:0]   i_count,
    output logic                         o_done,
    output logic                         o_ok,
    output logic [cpsa_pkg::PAGE_W-1:0]  o_result_page,
    output logic [cpsa_pkg::FREE_W-1:0]  o_free_slots,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [cpsa_pkg::PAGE_W-1:0]  i_cfg_data
);
    import cpsa_pkg::*;

    logic [PAGE_W-1:0] r_direct;
    t_q_stat           w_q_stat;
    t_cmd              w_push_cmd;
    t_cmd              w_head_cmd;
    logic              w_push;
    logic              w_pop;
    t_cfg_wr           w_cfg;

    // the user must write config only while idle; the block does not enforce it, so always take it
    assign o_cfg_ready = 1'b1;
    assign w_cfg.we    = i_cfg_valid && o_cfg_ready;
    assign w_cfg.data  = i_cfg_data;

    // hold the direct-mapped limit; a write reinitializes the back end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direct <= PAGE_W'(DIRECT_RESET);
        end else if (w_cfg.we) begin
            r_direct <= i_cfg_data;
        end
    end

    cpsa_front u_front (
        .i_start       (i_start),
        .i_op          (i_op),
        .i_page_number (i_page_number),
        .i_count       (i_count),
        .i_direct      (r_direct),
        .i_q_stat      (w_q_stat),
        .o_busy        (o_busy),
        .o_push        (w_push),
        .o_cmd         (w_push_cmd)
    );

    cpsa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_head_cmd),
        .o_stat  (w_q_stat)
    );

    cpsa_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (w_cfg),
        .i_direct      (r_direct),
        .i_q_stat      (w_q_stat),
        .i_cmd         (w_head_cmd),
        .o_pop         (w_pop),
        .o_done        (o_done),
        .o_ok          (o_ok),
        .o_result_page (o_result_page),
        .o_free_slots  (o_free_slots)
    );

endmodule

[bench/slot_alloc_checker.sv]
// Checker for the slot allocator: tracks the occupancy map and compares every result.
`timescale 1ns / 100ps

module slot_alloc_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic                        i_busy,
    input  logic [1:0]                  i_op,
    input  logic [cpsa_pkg::PAGE_W-1:0] i_page_number,
    input  logic [cpsa_pkg::RUN_W-1:0]  i_count,
    input  logic                        i_done,
    input  logic                        i_ok,
    input  logic [cpsa_pkg::PAGE_W-1:0] i_result_page,
    input  logic [cpsa_pkg::FREE_W-1:0] i_free_slots,
    input  logic                        i_cfg_valid,
    input  logic                        i_cfg_ready,
    input  logic [cpsa_pkg::PAGE_W-1:0] i_cfg_data,
    output int                          o_pending,
    output int                          o_failures
);
    import cpsa_pkg::*;

    typedef struct {
        logic              ok;
        logic [PAGE_W-1:0] page;
        logic [FREE_W-1:0] free;
    } t_answer;

    // mirror of the block state
    bit                slot_busy [TOTAL_PAGES];
    int                hint;
    int                free_cnt;
    int                direct;
    t_answer           answer_q [$];

    assign o_pending = answer_q.size();

    function automatic int slot_span();
        return (direct >= TOTAL_PAGES) ? 0 : TOTAL_PAGES - direct;
    endfunction

    function automatic void restart(int dp);
        int n;
        direct = dp;
        n = slot_span();
        foreach (slot_busy[k]) slot_busy[k] = 1'b0;
        hint = (n > 0) ? n - 1 : 0;
        free_cnt = (n > FREE_MAX) ? FREE_MAX : n;
    endfunction

    function automatic bit open_slot(int s);
        return s < slot_span() && s < TOTAL_PAGES && !slot_busy[s];
    endfunction

    function automatic void take(int n);
        free_cnt = (free_cnt > n) ? free_cnt - n : 0;
    endfunction

    // Work out the answer to one command and advance the mirror.
    function automatic t_answer run_command(t_op op, int page, int cnt);
        t_answer a;
        int      i, head, s;
        bit      fit;
        a.ok = 1'b0;
        a.page = '0;
        case (op)
            OP_ALLOC: begin
                if (cnt >= 1 && cnt <= MAX_RUN) begin
                    for (int p = hint; p >= cnt; p--) begin
                        fit = 1'b1;
                        for (i = 0; i < cnt; i++) begin
                            if (!open_slot(p - i)) fit = 1'b0;
                        end
                        if (fit) begin
                            head = p - cnt + 1;
                            for (i = 0; i < cnt; i++) slot_busy[head + i] = 1'b1;
                            if (p == hint) hint = head - 1;
                            take(cnt);
                            a.ok = 1'b1;
                            a.page = PAGE_W'(direct + head);
                            break;
                        end
                    end
                end
            end
            OP_MAP: begin
                if (page < direct) begin
                    a.ok = 1'b1;
                    a.page = PAGE_W'(page);
                end else begin
                    for (int p = hint; p >= 1; p--) begin
                        if (open_slot(p)) begin
                            slot_busy[p] = 1'b1;
                            take(1);
                            hint = p;
                            a.ok = 1'b1;
                            a.page = PAGE_W'(direct + p);
                            break;
                        end
                    end
                end
            end
            OP_FREE: begin
                if (cnt >= 1 && cnt <= MAX_RUN) begin
                    if (page < direct) begin
                        a.ok = 1'b1;
                    end else begin
                        s = page - direct;
                        if (s + cnt <= slot_span()) begin
                            for (i = 0; i < cnt; i++) slot_busy[s + i] = 1'b0;
                            if (s + cnt - 1 > hint) hint = s + cnt - 1;
                            a.ok = 1'b1;
                        end
                        free_cnt += cnt;
                        if (free_cnt > FREE_MAX) free_cnt = FREE_MAX;
                    end
                end
            end
            default: ;
        endcase
        a.free = FREE_W'(free_cnt);
        return a;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            restart(DIRECT_RESET);
            answer_q.delete();
            o_failures <= 0;
        end else begin
            // result first: it belongs to a command taken on an earlier edge
            if (i_done) begin
                if (answer_q.size() == 0) begin
                    $error("result with nothing outstanding: ok=%0d page=%0d free=%0d",
                           i_ok, i_result_page, i_free_slots);
                    o_failures <= o_failures + 1;
                end else begin
                    want = answer_q.pop_front();
                    if (i_ok !== want.ok || i_result_page !== want.page ||
                        i_free_slots !== want.free) begin
                        if (i_ok !== want.ok)
                            $error("ok: expected %0d, got %0d", want.ok, i_ok);
                        if (i_result_page !== want.page)
                            $error("result_page: expected %0d, got %0d",
                                   want.page, i_result_page);
                        if (i_free_slots !== want.free)
                            $error("free_slots: expected %0d, got %0d",
                                   want.free, i_free_slots);
                        o_failures <= o_failures + 1;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) restart(int'(i_cfg_data));
            if (i_start && !i_busy)
                answer_q.push_back(run_command(t_op'(i_op), int'(i_page_number),
                                               int'(i_count)));
        end
    end

endmodule

[bench/testbench.sv]
// Top of the slot allocator bench: clock, reset, command stimulus and verdict.
`timescale 1ns / 100ps

module testbench;
    import cpsa_pkg::*;

    localparam longint CYCLE_LIMIT = 20_000_000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    logic              o_busy;
    logic [1:0]        i_op = OP_NONE;
    logic [PAGE_W-1:0] i_page_number = '0;
    logic [RUN_W-1:0]  i_count = '0;
    logic              o_done;
    logic              o_ok;
    logic [PAGE_W-1:0] o_result_page;
    logic [FREE_W-1:0] o_free_slots;
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic [PAGE_W-1:0] i_cfg_data = '0;

    int     outstanding;
    int     failures;
    longint cycles = 0;
    int     direct_now = DIRECT_RESET;

    always #4 i_clk = ~i_clk;

    contiguous_page_slot_allocator uut (
        .i_clk, .i_rst_n, .i_start, .o_busy, .i_op, .i_page_number, .i_count,
        .o_done, .o_ok, .o_result_page, .o_free_slots,
        .i_cfg_valid, .o_cfg_ready, .i_cfg_data
    );

    slot_alloc_checker scoreboard (
        .i_clk, .i_rst_n, .i_start, .i_busy(o_busy), .i_op, .i_page_number, .i_count,
        .i_done(o_done), .i_ok(o_ok), .i_result_page(o_result_page),
        .i_free_slots(o_free_slots), .i_cfg_valid, .i_cfg_ready(o_cfg_ready),
        .i_cfg_data, .o_pending(outstanding), .o_failures(failures)
    );

    // Watchdog: a hung scan must not hang the run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // Mostly back-to-back or short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 45) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 5);
    endfunction

    // Hold the command until it transfers; lower start only if a gap follows.
    task automatic issue(t_op op, int page, int cnt, int gap);
        i_start <= 1'b1;
        i_op <= op;
        i_page_number <= PAGE_W'(page);
        i_count <= RUN_W'(cnt);
        do @(posedge i_clk); while (o_busy);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drop start at the edge of the last transfer, then wait out every answer.
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
    endtask

    // Write direct_pages only with the block idle.
    task automatic set_direct(int dp);
        drain();
        repeat (4) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= PAGE_W'(dp);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        direct_now = dp;
        repeat ($urandom_range(3)) @(posedge i_clk);
    endtask

    // Random command, biased toward legal runs inside the dynamic region.
    task automatic random_command();
        int r, page, cnt;
        t_op op;
        r = $urandom_range(99);
        op = (r < 40) ? OP_ALLOC : (r < 72) ? OP_FREE : (r < 95) ? OP_MAP : OP_NONE;
        cnt = ($urandom_range(9) == 0) ? $urandom_range(31) : $urandom_range(MAX_RUN, 1);
        if ($urandom_range(4) != 0 && direct_now < TOTAL_PAGES - 1)
            page = $urandom_range(TOTAL_PAGES - 1, direct_now);
        else
            page = $urandom_range(TOTAL_PAGES - 1);
        issue(op, page, cnt, pick_gap());
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: field extremes, every op, bad counts, direct pass-through.
        issue(OP_ALLOC, 0, 1, 0);
        issue(OP_ALLOC, 0, MAX_RUN, 1);
        issue(OP_ALLOC, 0, 0, 0);
        issue(OP_ALLOC, 0, 17, 0);
        issue(OP_ALLOC, 4095, 31, 2);
        issue(OP_MAP, 0, 0, 0);
        issue(OP_MAP, 1023, 5, 0);
        issue(OP_MAP, 4095, 1, 0);
        issue(OP_FREE, 100, 4, 0);
        issue(OP_FREE, 4095, 16, 0);
        issue(OP_FREE, 4080, 16, 3);
        issue(OP_FREE, 2000, 0, 0);
        issue(OP_NONE, 4095, 31, 0);
        issue(OP_ALLOC, 0, 8, 0);

        // One dynamic slot: slot 0 is never handed out.
        set_direct(4095);
        issue(OP_ALLOC, 0, 1, 0);
        issue(OP_MAP, 4095, 1, 0);
        issue(OP_FREE, 4095, 1, 0);
        issue(OP_FREE, 4095, 2, 0);

        // Every page dynamic.
        set_direct(0);
        issue(OP_MAP, 0, 1, 0);
        issue(OP_ALLOC, 0, 16, 0);
        issue(OP_FREE, 4080, 16, 0);

        // Push the free count into saturation.
        set_direct(1);
        for (int k = 0; k < 270; k++) issue(OP_FREE, 4080, 16, (k % 7 == 0) ? 2 : 0);
        for (int k = 0; k < 20; k++) random_command();

        // Small regions: failed scans stay short.
        set_direct(4000);
        for (int k = 0; k < 100; k++) random_command();
        set_direct(3968);
        for (int k = 0; k < 120; k++) random_command();
        drain();  // hold off until every answer is back
        repeat (5) @(posedge i_clk);
        for (int k = 0; k < 60; k++) random_command();
        set_direct($urandom_range(4094, 3900));
        for (int k = 0; k < 60; k++) random_command();
        set_direct(1024);
        for (int k = 0; k < 80; k++) random_command();

        drain();
        repeat (50) @(posedge i_clk);
        if (failures == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/cpsa_pkg.sv
src/cpsa_front.sv
src/cpsa_queue.sv
src/cpsa_back.sv
src/contiguous_page_slot_allocator.sv
bench/slot_alloc_checker.sv
bench/testbench.sv
